// ----- design/dts_pkg.sv -----
// Shared types and constants of the dataflow task scheduler.
// No dependencies; every other design file imports this package.
package dts_pkg;

   localparam logic [2:0] OP_WR_IN   = 3'd0;
   localparam logic [2:0] OP_WR_OUT  = 3'd1;
   localparam logic [2:0] OP_COUNTS  = 3'd2;
   localparam logic [2:0] OP_PRESET  = 3'd3;
   localparam logic [2:0] OP_START   = 3'd4;
   localparam logic [2:0] OP_FINISH  = 3'd5;

   localparam logic REG_TASKS_IN_USE  = 1'b0;
   localparam logic REG_COLLECT_LIMIT = 1'b1;

   localparam logic [5:0] TASKS_IN_USE_RESET  = 6'd32;
   localparam logic [6:0] COLLECT_LIMIT_RESET = 7'd64;

   typedef struct packed {
      logic [2:0] opcode;
      logic [4:0] task_index;
      logic [2:0] slot;
      logic [5:0] buffer_index;
      logic [3:0] count_in;
      logic [2:0] count_out;
   } req_type;

   typedef struct packed {
      logic [4:0] ready_task;
      logic       found;
   } rsp_type;

   typedef struct packed {
      logic [5:0] tasks_in_use;
      logic [6:0] collect_limit;
   } cfg_type;

   // One queued item together with the front's classification of it.
   typedef struct packed {
      req_type req;
      logic    task_ok;
   } entry_type;

endpackage

// ----- design/dts_csr.sv -----
// Configuration registers of the dataflow task scheduler behind an APB-style port.
// Depends on dts_pkg.
module dts_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output dts_pkg::cfg_type  cfg
);
   import dts_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[2])
            REG_TASKS_IN_USE:  cfg_in.tasks_in_use  = pwdata[5:0];
            REG_COLLECT_LIMIT: cfg_in.collect_limit = pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_TASKS_IN_USE:  prdata = {26'd0, cfg_ff.tasks_in_use};
         REG_COLLECT_LIMIT: prdata = {25'd0, cfg_ff.collect_limit};
         default:           prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tasks_in_use  <= TASKS_IN_USE_RESET;
         cfg_ff.collect_limit <= COLLECT_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- design/dts_front.sv -----
// Front end of the dataflow task scheduler: takes items, classifies them and queues them.
// Depends on dts_pkg.
module dts_front #(
   parameter int MAX_TASKS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  dts_pkg::req_type    req_data,
   output logic                busy,
   output logic                q_valid,
   output dts_pkg::entry_type  q_entry,
   input  logic                q_pop
);
   import dts_pkg::*;

   entry_type  entries_ff [2];
   entry_type  entries_in [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       do_pop;

   assign busy    = (count_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (count_ff != 2'd0);
   assign q_entry = entries_ff[rptr_ff];
   assign do_pop  = q_pop && q_valid;

   always_comb begin
      entries_in = entries_ff;
      wptr_in    = wptr_ff;
      rptr_in    = rptr_ff;
      count_in   = count_ff;
      if (push) begin
         entries_in[wptr_ff].req     = req_data;
         entries_in[wptr_ff].task_ok = (32'(req_data.task_index) < MAX_TASKS);
         wptr_in = !wptr_ff;
      end
      if (do_pop) begin
         rptr_in = !rptr_ff;
      end
      count_in = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- design/dts_back.sv -----
// Back end of the dataflow task scheduler: task table, buffer state and the scan sequencer.
// Depends on dts_pkg; takes queued items from dts_front.
module dts_back #(
   parameter int MAX_TASKS    = 32,
   parameter int MAX_BUFFERS  = 64,
   parameter int INPUT_SLOTS  = 8,
   parameter int OUTPUT_SLOTS = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  dts_pkg::cfg_type    cfg,
   input  logic                q_valid,
   input  dts_pkg::entry_type  q_entry,
   output logic                q_pop,
   output logic                rsp_valid,
   output dts_pkg::rsp_type    rsp_data
);
   import dts_pkg::*;

   localparam int TIW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int TCW  = $clog2(MAX_TASKS + 1);
   localparam int BIW  = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
   localparam int LCW  = $clog2(MAX_BUFFERS + 1);
   localparam int ICW  = $clog2(INPUT_SLOTS + 1);
   localparam int OCW  = $clog2(OUTPUT_SLOTS + 1);
   localparam int MAXS = (INPUT_SLOTS > OUTPUT_SLOTS) ? INPUT_SLOTS : OUTPUT_SLOTS;
   localparam int SCW  = $clog2(MAXS + 1);
   localparam int IDEP = MAX_TASKS * INPUT_SLOTS;
   localparam int ODEP = MAX_TASKS * OUTPUT_SLOTS;
   localparam int IAW  = (IDEP > 1) ? $clog2(IDEP) : 1;
   localparam int OAW  = (ODEP > 1) ? $clog2(ODEP) : 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_TASK = 3'd1;
   localparam logic [2:0] S_SLOT = 3'd2;
   localparam logic [2:0] S_EVAL = 3'd3;
   localparam logic [2:0] S_REL  = 3'd4;

   localparam logic [1:0] PH_FILL   = 2'd0;
   localparam logic [1:0] PH_DONE   = 2'd1;
   localparam logic [1:0] PH_MARK   = 2'd2;
   localparam logic [1:0] PH_REPORT = 2'd3;

   logic [2:0]             state_ff, state_in;
   logic [1:0]             phase_ff, phase_in;
   logic [TCW-1:0]         tc_ff, tc_in;
   logic [SCW-1:0]         sc_ff, sc_in;
   logic                   acc_ff, acc_in;
   entry_type              cmd_ff, cmd_in;
   logic [MAX_BUFFERS-1:0] filled_ff, filled_in;
   logic [MAX_BUFFERS-1:0] rbu_ff, rbu_in;
   logic [MAX_TASKS-1:0]   done_ff, done_in;
   logic [ICW-1:0]         icnt_ff [MAX_TASKS];
   logic [ICW-1:0]         icnt_in [MAX_TASKS];
   logic [OCW-1:0]         ocnt_ff [MAX_TASKS];
   logic [OCW-1:0]         ocnt_in [MAX_TASKS];
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [5:0]             in_list_ff  [IDEP];
   logic [5:0]             out_list_ff [ODEP];
   logic [5:0]             in_rd_ff, out_rd_ff;
   logic                   in_we, out_we;
   logic [IAW-1:0]         in_waddr, in_raddr;
   logic [OAW-1:0]         out_waddr, out_raddr;

   logic [TCW-1:0]         n_scan;
   logic [LCW-1:0]         lim;
   logic [MAX_BUFFERS-1:0] lim_mask;
   logic [TIW-1:0]         tci;
   logic [SCW-1:0]         cnt;
   logic [5:0]             rd_buf;
   logic                   rd_ok;
   logic [BIW-1:0]         rd_idx;
   logic                   q_ok;
   logic [BIW-1:0]         q_idx;
   logic [TIW-1:0]         q_ti;

   assign q_ok  = (32'(q_entry.req.buffer_index) < MAX_BUFFERS);
   assign q_idx = BIW'(32'(q_entry.req.buffer_index));
   assign q_ti  = TIW'(32'(q_entry.req.task_index));

   assign n_scan = (32'(cfg.tasks_in_use) > MAX_TASKS) ? TCW'(MAX_TASKS)
                                                       : TCW'(32'(cfg.tasks_in_use));
   assign lim    = (32'(cfg.collect_limit) > MAX_BUFFERS) ? LCW'(MAX_BUFFERS)
                                                          : LCW'(32'(cfg.collect_limit));
   always_comb begin
      for (int b = 0; b < MAX_BUFFERS; b++) begin
         lim_mask[b] = (LCW'(b) < lim);
      end
   end

   assign tci    = TIW'(32'(tc_ff));
   assign cnt    = (phase_ff == PH_FILL || phase_ff == PH_DONE) ? SCW'(ocnt_ff[tci])
                                                               : SCW'(icnt_ff[tci]);
   assign rd_buf = (phase_ff == PH_FILL || phase_ff == PH_DONE) ? out_rd_ff : in_rd_ff;
   assign rd_ok  = (32'(rd_buf) < MAX_BUFFERS);
   assign rd_idx = BIW'(32'(rd_buf));

   assign in_raddr  = IAW'(32'(tc_ff) * INPUT_SLOTS + 32'(sc_ff));
   assign out_raddr = OAW'(32'(tc_ff) * OUTPUT_SLOTS + 32'(sc_ff));
   assign in_waddr  = IAW'(32'(q_entry.req.task_index) * INPUT_SLOTS
                           + 32'(q_entry.req.slot));
   assign out_waddr = OAW'(32'(q_entry.req.task_index) * OUTPUT_SLOTS
                           + 32'(q_entry.req.slot));

   assign q_pop = (state_ff == S_IDLE);
   assign in_we  = q_pop && q_valid && (q_entry.req.opcode == OP_WR_IN) && q_entry.task_ok
                   && (32'(q_entry.req.slot) < INPUT_SLOTS);
   assign out_we = q_pop && q_valid && (q_entry.req.opcode == OP_WR_OUT) && q_entry.task_ok
                   && (32'(q_entry.req.slot) < OUTPUT_SLOTS);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      tc_in        = tc_ff;
      sc_in        = sc_ff;
      acc_in       = acc_ff;
      cmd_in       = cmd_ff;
      filled_in    = filled_ff;
      rbu_in       = rbu_ff;
      done_in      = done_ff;
      icnt_in      = icnt_ff;
      ocnt_in      = ocnt_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               cmd_in = q_entry;
               case (q_entry.req.opcode)
                  OP_COUNTS: begin
                     if (q_entry.task_ok) begin
                        icnt_in[q_ti] = (32'(q_entry.req.count_in) > INPUT_SLOTS)
                                        ? ICW'(INPUT_SLOTS) : ICW'(q_entry.req.count_in);
                        ocnt_in[q_ti] = (32'(q_entry.req.count_out) > OUTPUT_SLOTS)
                                        ? OCW'(OUTPUT_SLOTS) : OCW'(q_entry.req.count_out);
                     end
                  end
                  OP_PRESET: begin
                     if (q_ok) filled_in[q_idx] = 1'b1;
                  end
                  OP_START: begin
                     phase_in = PH_DONE;
                     tc_in    = '0;
                     state_in = S_TASK;
                  end
                  OP_FINISH: begin
                     phase_in = PH_FILL;
                     tc_in    = q_entry.task_ok ? TCW'(32'(q_entry.req.task_index)) : '0;
                     state_in = S_TASK;
                  end
                  default: ;
               endcase
            end
         end
         S_TASK: begin
            if (phase_ff == PH_FILL) begin
               if (!cmd_ff.task_ok) begin
                  phase_in = PH_DONE;
                  tc_in    = '0;
               end else begin
                  sc_in    = '0;
                  acc_in   = 1'b1;
                  state_in = S_SLOT;
               end
            end else if (tc_ff == n_scan) begin
               tc_in = '0;
               case (phase_ff)
                  PH_DONE: begin
                     if (cmd_ff.req.opcode == OP_FINISH) begin
                        phase_in = PH_MARK;
                        rbu_in   = '0;
                     end else begin
                        phase_in = PH_REPORT;
                     end
                  end
                  PH_MARK: state_in = S_REL;
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                     state_in     = S_IDLE;
                  end
               endcase
            end else if ((phase_ff == PH_MARK || phase_ff == PH_REPORT) && done_ff[tci]) begin
               tc_in = tc_ff + TCW'(1);
            end else begin
               sc_in    = '0;
               acc_in   = 1'b1;
               state_in = S_SLOT;
            end
         end
         S_SLOT: begin
            if (sc_ff == cnt) begin
               state_in = S_TASK;
               case (phase_ff)
                  PH_FILL: begin
                     phase_in = PH_DONE;
                     tc_in    = '0;
                  end
                  PH_DONE: begin
                     done_in[tci] = acc_ff;
                     tc_in        = tc_ff + TCW'(1);
                  end
                  PH_MARK: tc_in = tc_ff + TCW'(1);
                  default: begin
                     if (acc_ff) begin
                        rsp_valid_in           = 1'b1;
                        rsp_data_in.ready_task = 5'(32'(tc_ff));
                        rsp_data_in.found      = 1'b1;
                        state_in               = S_IDLE;
                     end else begin
                        tc_in = tc_ff + TCW'(1);
                     end
                  end
               endcase
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            case (phase_ff)
               PH_FILL: begin
                  if (rd_ok) filled_in[rd_idx] = 1'b1;
               end
               PH_MARK: begin
                  if (rd_ok) rbu_in[rd_idx] = 1'b1;
               end
               default: begin
                  if (!(rd_ok && filled_ff[rd_idx])) acc_in = 1'b0;
               end
            endcase
            sc_in    = sc_ff + SCW'(1);
            state_in = S_SLOT;
         end
         S_REL: begin
            // Release every filled buffer in range that no undone task still reads.
            filled_in = filled_ff & ~(~rbu_ff & lim_mask);
            phase_in  = PH_REPORT;
            tc_in     = '0;
            state_in  = S_TASK;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (in_we)  in_list_ff[in_waddr]   <= q_entry.req.buffer_index;
      if (out_we) out_list_ff[out_waddr] <= q_entry.req.buffer_index;
      in_rd_ff  <= in_list_ff[in_raddr];
      out_rd_ff <= out_list_ff[out_raddr];
   end

   always_ff @(posedge clock) begin
      phase_ff    <= phase_in;
      tc_ff       <= tc_in;
      sc_ff       <= sc_in;
      acc_ff      <= acc_in;
      cmd_ff      <= cmd_in;
      rbu_ff      <= rbu_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         filled_ff    <= '0;
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int t = 0; t < MAX_TASKS; t++) begin
            icnt_ff[t] <= '0;
            ocnt_ff[t] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         filled_ff    <= filled_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         icnt_ff      <= icnt_in;
         ocnt_ff      <= ocnt_in;
      end
   end

endmodule

// ----- design/dataflow_task_scheduler.sv -----
// Top level of the dataflow task scheduler: configuration port, front queue and back sequencer.
// Depends on dts_pkg, dts_csr, dts_front and dts_back.
//
//   channel   ports                          handshake
//   input     start, busy, req_data          taken when start is high and busy is low
//   result    rsp_valid, rsp_data            one-cycle strobe, cannot be held off
//   config    psel..pready, paddr 0 and 4    written in the access phase, pready always high
//
// Load items are applied by the back end in its idle state. A start item recomputes the done
// bits by scanning the outputs of each task in use, then scans the inputs of undone tasks
// up to the ready one; a finish adds the fill and mark scans and a release step. The list
// memories have a registered read port.
// A two-entry queue lets items arrive while the back end scans; busy rises when it is full.
// Reset clears counts, filled and done bits at once; the list memories are not cleared.
module dataflow_task_scheduler #(
   parameter int MAX_TASKS    = 32,
   parameter int MAX_BUFFERS  = 64,
   parameter int INPUT_SLOTS  = 8,
   parameter int OUTPUT_SLOTS = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dts_pkg::req_type  req_data,
   output logic              rsp_valid,
   output dts_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import dts_pkg::*;

   cfg_type   cfg;
   logic      q_valid;
   logic      q_pop;
   entry_type q_entry;

   dts_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dts_front #(.MAX_TASKS(MAX_TASKS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .busy     (busy),
      .q_valid  (q_valid),
      .q_entry  (q_entry),
      .q_pop    (q_pop)
   );

   dts_back #(
      .MAX_TASKS    (MAX_TASKS),
      .MAX_BUFFERS  (MAX_BUFFERS),
      .INPUT_SLOTS  (INPUT_SLOTS),
      .OUTPUT_SLOTS (OUTPUT_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- design/dts_checker.sv -----
// Port-level checks of the dataflow task scheduler, bound to the top level.
// Depends on dts_pkg and dataflow_task_scheduler.
module dts_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input dts_pkg::rsp_type rsp_data,
   input logic             pready
);
   import dts_pkg::*;

   // Each result ends a scan that begins from the idle state, so two results never come back to back.
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("results in consecutive cycles");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |-> (rsp_data.ready_task == 5'd0))
      else $error("task index set without a ready task");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid)) else $error("activity right after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready) else $error("configuration port stalled");

   // The queue only fills when an item is taken, so busy cannot rise without one.
   a_busy_entry: assert property (@(posedge clock) disable iff (reset)
      (!busy && !start) |=> !busy)
      else $error("queue accounting");

endmodule

bind dataflow_task_scheduler dts_checker u_dts_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data),
   .pready    (pready)
);

// ----- tb/tb.sv -----
// Self-checking testbench of the dataflow task scheduler: directed table, then random items.
// Depends on dts_pkg and the design top dataflow_task_scheduler; needs nothing else.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dts_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   dataflow_task_scheduler u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Scheduler image kept by the testbench.
   logic [5:0] in_list [256];
   bit         in_written [256];
   logic [5:0] out_list [128];
   bit         out_written [128];
   int         in_cnt [32];
   int         out_cnt [32];
   bit         filled [64];
   bit         done_bit [32];
   int         tasks_reg;
   int         limit_reg;

   rsp_type    ready_q[$];
   int         fail_cnt;
   int         items_sent;
   int         rsp_seen;
   int         found_seen;
   int         idle_pct;

   typedef struct {
      req_type r;
      bit      typed;
      rsp_type v;
   } row_type;

   function automatic int scan_n();
      return tasks_reg > 32 ? 32 : tasks_reg;
   endfunction

   function automatic bit inputs_ready(int t);
      for (int i = 0; i < in_cnt[t]; i++)
         if (!filled[in_list[t*8+i]]) return 0;
      return 1;
   endfunction

   function automatic void refresh_done();
      bit empty_out;
      for (int t = 0; t < scan_n(); t++) begin
         empty_out = 0;
         for (int j = 0; j < out_cnt[t]; j++)
            if (!filled[out_list[t*4+j]]) empty_out = 1;
         done_bit[t] = !empty_out;
      end
   endfunction

   function automatic void release_unread();
      bit readers [64];
      int lim;
      lim = limit_reg > 64 ? 64 : limit_reg;
      foreach (readers[b]) readers[b] = 0;
      for (int t = 0; t < scan_n(); t++)
         if (!done_bit[t])
            for (int i = 0; i < in_cnt[t]; i++) readers[in_list[t*8+i]] = 1;
      for (int b = 0; b < lim; b++)
         if (!readers[b]) filled[b] = 0;
   endfunction

   function automatic rsp_type pick_ready();
      rsp_type o;
      o = '0;
      for (int t = 0; t < scan_n(); t++)
         if (!done_bit[t] && inputs_ready(t)) begin
            o.ready_task = t[4:0];
            o.found = 1'b1;
            return o;
         end
      return o;
   endfunction

   // Applies one item to the image; returns 1 where the item gives a result.
   function automatic bit apply_item(req_type r, output rsp_type o);
      int t;
      t = r.task_index;
      o = '0;
      case (r.opcode)
         OP_WR_IN: begin
            in_list[t*8+r.slot] = r.buffer_index;
            in_written[t*8+r.slot] = 1;
         end
         OP_WR_OUT: begin
            if (r.slot < 4) begin
               out_list[t*4+r.slot] = r.buffer_index;
               out_written[t*4+r.slot] = 1;
            end
         end
         OP_COUNTS: begin
            in_cnt[t] = r.count_in > 8 ? 8 : r.count_in;
            out_cnt[t] = r.count_out > 4 ? 4 : r.count_out;
         end
         OP_PRESET: filled[r.buffer_index] = 1;
         OP_START: begin
            refresh_done();
            o = pick_ready();
            return 1;
         end
         OP_FINISH: begin
            for (int j = 0; j < out_cnt[t]; j++) filled[out_list[t*4+j]] = 1;
            refresh_done();
            release_unread();
            o = pick_ready();
            return 1;
         end
         default: ;
      endcase
      return 0;
   endfunction

   function automatic req_type make_req(logic [2:0] op, int t, int s, int b, int ci, int co);
      req_type r;
      r.opcode = op;
      r.task_index = 5'(t);
      r.slot = 3'(s);
      r.buffer_index = 6'(b);
      r.count_in = 4'(ci);
      r.count_out = 3'(co);
      return r;
   endfunction

   function automatic req_type random_req();
      req_type r;
      int pick;
      r = req_type'(24'($urandom));
      pick = $urandom_range(99);
      if (pick < 15) r.opcode = OP_WR_IN;
      else if (pick < 25) r.opcode = OP_WR_OUT;
      else if (pick < 40) r.opcode = OP_COUNTS;
      else if (pick < 55) r.opcode = OP_PRESET;
      else if (pick < 72) r.opcode = OP_START;
      else if (pick < 96) r.opcode = OP_FINISH;
      else r.opcode = 3'($urandom_range(6, 7));
      // Small task and buffer ranges make tasks share buffers and fire often.
      if ($urandom_range(99) < 80) r.task_index = 5'($urandom_range(0, 7));
      if ($urandom_range(99) < 85) r.buffer_index = 6'($urandom_range(0, 15));
      return r;
   endfunction

   task automatic drive_item(req_type r, bit typed, rsp_type tv);
      rsp_type p;
      bit has;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      forever begin
         @(negedge clock);
         if (!busy) break;
         @(posedge clock);
      end
      has = apply_item(r, p);
      if (has) ready_q.push_back(typed ? tv : p);
      @(posedge clock);
      items_sent++;
   endtask

   // A count write first fills every slot it covers, so no unwritten list entry is read.
   task automatic issue(req_type r);
      int t;
      int n_in;
      int n_out;
      t = r.task_index;
      if (r.opcode == OP_COUNTS) begin
         n_in = r.count_in > 8 ? 8 : r.count_in;
         n_out = r.count_out > 4 ? 4 : r.count_out;
         for (int s = 0; s < n_in; s++)
            if (!in_written[t*8+s])
               drive_item(make_req(OP_WR_IN, t, s, $urandom_range(0, 15), 0, 0), 0, '0);
         for (int s = 0; s < n_out; s++)
            if (!out_written[t*4+s])
               drive_item(make_req(OP_WR_OUT, t, s, $urandom_range(0, 15), 0, 0), 0, '0);
      end
      drive_item(r, 0, '0);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (ready_q.size() != 0) @(posedge clock);
      // Load items give no result and may still be in the queue.
      repeat (2000) @(posedge clock);
   endtask

   task automatic csr_write(logic reg_sel, int value);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= 3'(reg_sel) << 2;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (reg_sel == REG_TASKS_IN_USE) tasks_reg = value & 32'h3F;
      else limit_reg = value & 32'h7F;
   endtask

   always @(negedge clock) begin
      if (!reset && rsp_valid) begin
         if (ready_q.size() == 0) begin
            $error("unexpected result ready_task=%0d found=%0b", rsp_data.ready_task,
                   rsp_data.found);
            fail_cnt++;
         end else begin
            if (rsp_data.ready_task !== ready_q[0].ready_task) begin
               $error("ready_task: expected %0d, actual %0d", ready_q[0].ready_task,
                      rsp_data.ready_task);
               fail_cnt++;
            end
            if (rsp_data.found !== ready_q[0].found) begin
               $error("found: expected %0b, actual %0b", ready_q[0].found, rsp_data.found);
               fail_cnt++;
            end
            if (rsp_data.found === 1'b1) found_seen++;
            void'(ready_q.pop_front());
         end
         rsp_seen++;
      end
   end

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("** dataflow_task_scheduler: FAILED **");
      $finish;
   end

   initial begin
      row_type rows[$];
      int      tasks_set [6] = '{32, 0, 63, 8, 5, 32};
      int      limit_set [6] = '{64, 0, 127, 6, 40, 64};
      int      sender_pct [3] = '{23, 52, 0};

      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      foreach (in_written[i]) in_written[i] = 0;
      foreach (out_written[i]) out_written[i] = 0;
      foreach (in_cnt[i]) begin
         in_cnt[i] = 0;
         out_cnt[i] = 0;
         done_bit[i] = 0;
      end
      foreach (filled[i]) filled[i] = 0;
      tasks_reg = TASKS_IN_USE_RESET;
      limit_reg = COLLECT_LIMIT_RESET;
      idle_pct = sender_pct[0];
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // After reset every task has no outputs, so all are done and none is ready.
      rows.push_back('{make_req(OP_START, 0, 0, 0, 0, 0), 1, '{5'd0, 1'b0}});
      rows.push_back('{make_req(OP_WR_IN, 0, 0, 1, 0, 0), 0, '0});
      rows.push_back('{make_req(OP_WR_OUT, 0, 0, 2, 0, 0), 0, '0});
      rows.push_back('{make_req(OP_COUNTS, 0, 0, 0, 1, 1), 0, '0});
      rows.push_back('{make_req(OP_START, 0, 0, 0, 0, 0), 1, '{5'd0, 1'b0}});
      rows.push_back('{make_req(OP_PRESET, 0, 0, 1, 0, 0), 0, '0});
      rows.push_back('{make_req(OP_START, 0, 0, 0, 0, 0), 1, '{5'd0, 1'b1}});
      rows.push_back('{make_req(OP_FINISH, 0, 0, 0, 0, 0), 1, '{5'd0, 1'b0}});
      // Output slot beyond the list is ignored.
      rows.push_back('{make_req(OP_WR_OUT, 1, 7, 63, 0, 0), 0, '0});
      // Oversized counts saturate; all-ones fields in every position.
      rows.push_back('{make_req(OP_COUNTS, 31, 7, 63, 15, 7), 0, '0});
      rows.push_back('{make_req(OP_START, 31, 7, 63, 15, 7), 0, '0});
      rows.push_back('{make_req(OP_PRESET, 0, 0, 63, 0, 0), 0, '0});
      rows.push_back('{make_req(OP_FINISH, 31, 0, 0, 0, 0), 0, '0});
      rows.push_back('{make_req(3'd6, 31, 7, 63, 15, 7), 0, '0});
      rows.push_back('{make_req(3'd7, 0, 0, 0, 0, 0), 0, '0});
      // Finish of a task with no outputs and not in any sense ready.
      rows.push_back('{make_req(OP_FINISH, 5, 0, 0, 0, 0), 0, '0});
      rows.push_back('{make_req(OP_START, 0, 0, 0, 0, 0), 0, '0});
      foreach (rows[i]) begin
         if (rows[i].typed) drive_item(rows[i].r, 1, rows[i].v);
         else issue(rows[i].r);
      end

      for (int ph = 0; ph < 6; ph++) begin
         settle();
         csr_write(REG_TASKS_IN_USE, tasks_set[ph]);
         csr_write(REG_COLLECT_LIMIT, limit_set[ph]);
         idle_pct = sender_pct[ph % 3];
         for (int k = 0; k < 50; k++) begin
            if (ph == 1 && k == 30) begin
               start <= 1'b0;
               do @(posedge clock); while (ready_q.size() != 0);
            end
            issue(random_req());
         end
      end

      settle();
      $display("Sent %0d items over six register settings; %0d results checked, %0d found.",
               items_sent, rsp_seen, found_seen);
      if (fail_cnt == 0) begin
         $display("** dataflow_task_scheduler: PASSED **");
      end else begin
         $display("** dataflow_task_scheduler: FAILED **");
      end
      $finish;
   end

endmodule

// ----- dataflow_task_scheduler.f -----
design/dts_pkg.sv
design/dts_csr.sv
design/dts_front.sv
design/dts_back.sv
design/dataflow_task_scheduler.sv
design/dts_checker.sv
tb/tb.sv
